// File: rtl/core/stwq_pkg.sv
package stwq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TIME_BITS   = 48;
    localparam int TASK_BITS   = 8;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = IDX_W + 2;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_POLL   = 1'b1;

    typedef logic [TIME_BITS-1:0] t_time;
    typedef logic [TASK_BITS-1:0] t_task;
    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [IDX_W:0]       t_ofs;
    typedef logic [CNT_W-1:0]     t_count;

    typedef struct packed {
        t_time wake;
        t_task id;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // ring position: base plus offset, folded back into the slot range
    function automatic t_idx wrap_add(input t_idx base, input t_ofs ofs);
        logic [SUM_W-1:0] s;
        s = SUM_W'(base) + SUM_W'(ofs);
        if (s >= SUM_W'(QUEUE_DEPTH)) begin
            s = s - SUM_W'(QUEUE_DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

endpackage

// File: rtl/core/stwq_ram.sv
module stwq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/sorted_timer_wakeup_queue_core.sv
// Sorted wake-up queue: up to QUEUE_DEPTH task handles, kept in wake-time
// order in a ring buffer held in a single-port-read RAM, with the head entry
// mirrored in registers. Issue a command by raising start while busy is low;
// one result follows, shown for exactly one cycle with o_valid high, and the
// receiver cannot stall it, so capture it on that cycle. An insert walks the
// ring from the tail toward the head, one entry per cycle through the RAM's
// registered read port, moving each later entry up by one slot until it finds
// its place; if it passes every entry it becomes the head. An insert into an
// empty or full queue and a poll that removes nothing go straight to the
// result; a poll that removes the head passes through a head-reload state
// while entries remain (one RAM read refreshes the head copy). Equal wake
// times leave in arrival order. A full queue refuses an insert with insert_ok
// low. Busy stays high through the result cycle.
module sorted_timer_wakeup_queue_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   i_command,
    input  stwq_pkg::t_time        i_wake_time,
    input  stwq_pkg::t_task        i_task_id,
    input  stwq_pkg::t_time        i_current_time,
    output logic                   o_valid,
    output logic                   o_insert_ok,
    output logic                   o_ready_valid,
    output stwq_pkg::t_task        o_ready_task,
    output stwq_pkg::t_time        o_ready_time,
    output logic                   o_next_valid,
    output stwq_pkg::t_time        o_next_time,
    output stwq_pkg::t_count       o_entry_count
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;  // compare entry k, shift it up or drop new item in
    localparam logic [2:0] S_PUT  = 3'd2;  // new item becomes the head
    localparam logic [2:0] S_HEAD = 3'd3;  // reload head copy after a poll
    localparam logic [2:0] S_RES  = 3'd4;

    // control state
    logic [2:0]          r_state, n_state;
    stwq_pkg::t_count    r_count, n_count;
    stwq_pkg::t_idx      r_head,  n_head;   // ring slot of the earliest entry

    // working and result payload
    stwq_pkg::t_idx      r_k,     n_k;      // queue position being examined
    stwq_pkg::t_entry    r_new,   n_new;
    stwq_pkg::t_entry    r_first, n_first;  // copy of the head entry
    logic                r_ins_ok, n_ins_ok;
    logic                r_rdy,    n_rdy;
    stwq_pkg::t_entry    r_taken,  n_taken;

    // ram port
    logic                ram_we;
    stwq_pkg::t_idx      ram_waddr;
    stwq_pkg::t_entry    ram_wdata;
    stwq_pkg::t_idx      ram_raddr;
    stwq_pkg::t_entry    ram_rdata;
    logic [stwq_pkg::ENTRY_W-1:0] ram_rbits;

    stwq_pkg::t_count    count_m1;
    stwq_pkg::t_ofs      k_plus1;

    stwq_ram #(
        .WIDTH (stwq_pkg::ENTRY_W),
        .DEPTH (stwq_pkg::QUEUE_DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rbits)
    );

    assign ram_rdata = stwq_pkg::t_entry'(ram_rbits);
    assign count_m1  = r_count - stwq_pkg::t_count'(1);
    assign k_plus1   = stwq_pkg::t_ofs'(r_k) + stwq_pkg::t_ofs'(1);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_head   = r_head;
        n_k      = r_k;
        n_new    = r_new;
        n_first  = r_first;
        n_ins_ok = r_ins_ok;
        n_rdy    = r_rdy;
        n_taken  = r_taken;
        ram_we    = 1'b0;
        ram_waddr = r_head;
        ram_wdata = r_new;
        ram_raddr = r_head;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_new.wake = i_wake_time;
                    n_new.id   = i_task_id;
                    n_ins_ok   = 1'b0;
                    n_rdy      = 1'b0;
                    n_taken    = '0;
                    n_state    = S_RES;
                    if (i_command == stwq_pkg::CMD_INSERT) begin
                        if (r_count == stwq_pkg::t_count'(0)) begin
                            // empty queue: the item lands at the head slot
                            ram_we     = 1'b1;
                            ram_waddr  = r_head;
                            ram_wdata  = n_new;
                            n_first    = n_new;
                            n_count    = stwq_pkg::t_count'(1);
                            n_ins_ok   = 1'b1;
                        end else if (r_count != stwq_pkg::t_count'(stwq_pkg::QUEUE_DEPTH)) begin
                            // start the walk at the tail entry
                            n_k       = count_m1[stwq_pkg::IDX_W-1:0];
                            ram_raddr = stwq_pkg::wrap_add(r_head, stwq_pkg::t_ofs'(n_k));
                            n_state   = S_SCAN;
                        end
                    end else begin
                        if (r_count != stwq_pkg::t_count'(0) &&
                            r_first.wake <= i_current_time) begin
                            n_rdy     = 1'b1;
                            n_taken   = r_first;
                            n_head    = stwq_pkg::wrap_add(r_head, stwq_pkg::t_ofs'(1));
                            n_count   = count_m1;
                            ram_raddr = n_head;
                            if (count_m1 != stwq_pkg::t_count'(0)) begin
                                n_state = S_HEAD;
                            end
                        end
                    end
                end
            end
            S_SCAN: begin
                ram_we    = 1'b1;
                ram_waddr = stwq_pkg::wrap_add(r_head, k_plus1);
                if (ram_rdata.wake > r_new.wake) begin
                    // later entry moves up one slot
                    ram_wdata = ram_rdata;
                    if (r_k == stwq_pkg::t_idx'(0)) begin
                        n_state = S_PUT;
                    end else begin
                        n_k       = r_k - stwq_pkg::t_idx'(1);
                        ram_raddr = stwq_pkg::wrap_add(r_head, stwq_pkg::t_ofs'(n_k));
                    end
                end else begin
                    // not later: new item goes right behind it
                    ram_wdata = r_new;
                    n_count   = r_count + stwq_pkg::t_count'(1);
                    n_ins_ok  = 1'b1;
                    n_state   = S_RES;
                end
            end
            S_PUT: begin
                ram_we    = 1'b1;
                ram_waddr = r_head;
                ram_wdata = r_new;
                n_first   = r_new;
                n_count   = r_count + stwq_pkg::t_count'(1);
                n_ins_ok  = 1'b1;
                n_state   = S_RES;
            end
            S_HEAD: begin
                n_first = ram_rdata;
                n_state = S_RES;
            end
            S_RES: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_head  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_head  <= n_head;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k      <= n_k;
        r_new    <= n_new;
        r_first  <= n_first;
        r_ins_ok <= n_ins_ok;
        r_rdy    <= n_rdy;
        r_taken  <= n_taken;
    end

    // result item, held in registers until the next command is accepted; o_valid marks the result cycle
    assign busy          = (r_state != S_IDLE);
    assign o_valid       = (r_state == S_RES);
    assign o_insert_ok   = r_ins_ok;
    assign o_ready_valid = r_rdy;
    assign o_ready_task  = r_rdy ? r_taken.id   : '0;
    assign o_ready_time  = r_rdy ? r_taken.wake : '0;
    assign o_next_valid  = (r_count != stwq_pkg::t_count'(0));
    assign o_next_time   = o_next_valid ? r_first.wake : '0;
    assign o_entry_count = r_count;

endmodule
